// ===== rtl/core/nearest_landmark_association_macros.svh =====
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH
`define NEAREST_LANDMARK_ASSOCIATION_MACROS_SVH

// same-cycle implication
`define NLA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nla assertion failed");

// next-cycle implication
`define NLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nla assertion failed");

`endif

// ===== rtl/core/nla_pkg.sv =====
package nla_pkg;

	localparam int ID_W = 16;
	localparam int COORD_W = 24;
	localparam int MAX_LANDMARKS_DEF = 64;

	// coordinate difference, its square and the sum of two squares
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int DIST_W = SQ_W + 1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                        operation;
		logic [ID_W-1:0]            landmark_id;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] matched_id;
		logic            found;
		logic            load_dropped;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} entry_t;

	typedef struct packed {
		logic            busy;
		logic            found;
		logic [ID_W-1:0] best_id;
	} scan_status_t;

endpackage

// ===== rtl/core/nla_ram.sv =====
module nla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/nla_dist.sv =====
module nla_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                entry_valid,
	input  nla_pkg::entry_t                     entry,
	input  logic signed [nla_pkg::COORD_W-1:0]  obs_x,
	input  logic signed [nla_pkg::COORD_W-1:0]  obs_y,
	output nla_pkg::scan_status_t               status
);

	import nla_pkg::*;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        adx;
	logic [DIFF_W-1:0]        ady;
	logic [DIST_W-1:0]        dist_sum;

	logic                     valid_s2;
	logic [DIFF_W-1:0]        adx_s2;
	logic [DIFF_W-1:0]        ady_s2;
	logic [ID_W-1:0]          id_s2;

	logic                     valid_s3;
	logic [SQ_W-1:0]          sqx_s3;
	logic [SQ_W-1:0]          sqy_s3;
	logic [ID_W-1:0]          id_s3;

	logic                     have_q;
	logic [DIST_W-1:0]        best_dist_q;
	logic [ID_W-1:0]          best_id_q;

	// sign-extended difference, magnitude fits unsigned in DIFF_W bits
	assign dx = {entry.x[COORD_W-1], entry.x} - {obs_x[COORD_W-1], obs_x};
	assign dy = {entry.y[COORD_W-1], entry.y} - {obs_y[COORD_W-1], obs_y};
	assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			adx_s2      <= '0;
			ady_s2      <= '0;
			id_s2       <= '0;
			valid_s3    <= 1'b0;
			sqx_s3      <= '0;
			sqy_s3      <= '0;
			id_s3       <= '0;
			have_q      <= 1'b0;
			best_dist_q <= '0;
			best_id_q   <= '0;
		end else begin
			valid_s2 <= entry_valid;
			adx_s2   <= adx;
			ady_s2   <= ady;
			id_s2    <= entry.id;

			valid_s3 <= valid_s2;
			sqx_s3   <= adx_s2 * adx_s2;
			sqy_s3   <= ady_s2 * ady_s2;
			id_s3    <= id_s2;

			// strict compare keeps the earliest entry on a tie
			if (start) begin
				have_q <= 1'b0;
			end else if (valid_s3 && (!have_q || dist_sum < best_dist_q)) begin
				have_q      <= 1'b1;
				best_dist_q <= dist_sum;
				best_id_q   <= id_s3;
			end
		end
	end

	assign status.busy    = valid_s2 | valid_s3;
	assign status.found   = have_q;
	assign status.best_id = have_q ? best_id_q : '0;

endmodule

// ===== rtl/core/nearest_landmark_association.sv =====
// channel   | direction | payload        | handshake
// ----------+-----------+----------------+----------------------
// req       | in        | nla_pkg::req_t | req_valid / req_ready
// rsp       | out       | nla_pkg::rsp_t | rsp_valid / rsp_ready
//
// clear and no-op give no response; a load answers through the response register
// a query reads the landmark memory one entry per cycle; the read port and the
// 3-stage distance pipeline lie between the reads and the response, and a query
// on an empty table is answered without a scan
// arst_n empties the table; memory contents are not cleared
// req_ready is low during a scan and while the spare response register is occupied
module nearest_landmark_association #(
	parameter int MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  nla_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output nla_pkg::rsp_t rsp
);

	import nla_pkg::*;

	localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CW = $clog2(MAX_LANDMARKS + 1);
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LANDMARKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             scan_idx_q;
	logic                      rd_valid_s1;
	logic signed [COORD_W-1:0] obs_x_q;
	logic signed [COORD_W-1:0] obs_y_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	logic                      hold_valid_q;
	rsp_t                      hold_q;

	logic                      accept;
	logic                      full;
	logic                      wr_en;
	logic                      rd_en;
	logic                      scan_start;
	logic                      drain_done;
	logic                      out_free;
	logic                      rsp_load;
	rsp_t                      rsp_new;
	entry_t                    wr_entry;
	entry_t                    rd_entry;
	scan_status_t              scan_status;

	assign full       = (count_q == COUNT_MAX);
	assign req_ready  = (state_q == ST_IDLE) && !hold_valid_q;
	assign accept     = req_valid && req_ready;
	assign wr_en      = accept && (req.operation == OP_LOAD) && !full;
	assign rd_en      = (state_q == ST_SCAN);
	assign scan_start = accept && (req.operation == OP_QUERY);
	// last read has left the memory and the pipeline is empty
	assign drain_done = (state_q == ST_DRAIN) && !rd_valid_s1 && !scan_status.busy;
	assign out_free   = !rsp_valid_q || rsp_ready;

	assign wr_entry.id = req.landmark_id;
	assign wr_entry.x  = req.point_x;
	assign wr_entry.y  = req.point_y;

	always_comb begin
		rsp_load = 1'b0;
		rsp_new  = '0;
		if (accept && (req.operation == OP_LOAD)) begin
			rsp_load             = 1'b1;
			rsp_new.load_dropped = full;
		end else if (accept && (req.operation == OP_QUERY) && (count_q == '0)) begin
			rsp_load = 1'b1;
		end else if (drain_done) begin
			rsp_load           = 1'b1;
			rsp_new.matched_id = scan_status.best_id;
			rsp_new.found      = scan_status.found;
		end
	end

	nla_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_LANDMARKS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	nla_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.entry_valid (rd_valid_s1),
		.entry       (rd_entry),
		.obs_x       (obs_x_q),
		.obs_y       (obs_y_q),
		.status      (scan_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			rd_valid_s1  <= 1'b0;
			obs_x_q      <= '0;
			obs_y_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			hold_valid_q <= 1'b0;
			hold_q       <= '0;
		end else begin
			rd_valid_s1 <= rd_en;
			// a response that finds the output busy waits in the spare register
			if (hold_valid_q) begin
				if (out_free) begin
					rsp_q        <= hold_q;
					rsp_valid_q  <= 1'b1;
					hold_valid_q <= 1'b0;
				end
			end else if (rsp_load) begin
				if (out_free) begin
					rsp_q       <= rsp_new;
					rsp_valid_q <= 1'b1;
				end else begin
					hold_q       <= rsp_new;
					hold_valid_q <= 1'b1;
				end
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.operation)
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_LOAD: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_QUERY: begin
								obs_x_q <= req.point_x;
								obs_y_q <= req.point_y;
								if (count_q != '0) begin
									scan_idx_q <= '0;
									state_q    <= ST_SCAN;
								end
							end
							OP_NOP: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + CW'(1);
					if (scan_idx_q + CW'(1) == count_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "nearest_landmark_association_macros.svh"

	`NLA_ASSERT_IMP(a_count_range, 1'b1, count_q <= COUNT_MAX)
	`NLA_ASSERT_IMP(a_scan_addr, rd_en, scan_idx_q < count_q)
	`NLA_ASSERT_IMP(a_drop_when_full, rsp_load && rsp_new.load_dropped, full && !wr_en)
	`NLA_ASSERT_IMP(a_no_hold_overrun, hold_valid_q, !rsp_load)
	`NLA_ASSERT_NEXT(a_query_scans, scan_start && (count_q != '0),
		(state_q == ST_SCAN) && !rsp_load)

endmodule
